>>> design/bult_pkg.sv
// Shared types, codes and constants for the bounded unsorted list table.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package bult_pkg;

	// Default sizes for the top-level parameters.
	localparam int DEF_MAX_ENTRIES = 16;
	localparam int DEF_KEY_WIDTH   = 32;

	// Fixed widths of the beat fields.
	localparam int CMD_W    = 3;
	localparam int IN_KEY_W = 32;
	localparam int STATUS_W = 3;
	localparam int POS_W    = 4;
	localparam int DATA_W   = 32;
	localparam int COUNT_W  = 5;

	localparam int IN_BEAT_W  = 40;
	localparam int OUT_BEAT_W = 48;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_UNIQUE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_REWIND = 3'd5;
	localparam logic [CMD_W-1:0] CMD_GET    = 3'd6;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd4;

	// Datapath action codes issued by the controller.
	localparam int ACT_W = 3;
	localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_DECODE  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_SCAN    = 3'd2;
	localparam logic [ACT_W-1:0] ACT_SHIFT   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_GET     = 3'd4;
	localparam logic [ACT_W-1:0] ACT_PUBLISH = 3'd5;

	// Input beat, last field in the lowest bits.
	typedef struct packed {
		logic [4:0]          pad;
		logic [IN_KEY_W-1:0] key;
		logic [CMD_W-1:0]    cmd;
	} in_beat_t;

	// Output beat, last field in the lowest bits.
	typedef struct packed {
		logic [2:0]          pad;
		logic [COUNT_W-1:0]  entry_count;
		logic [DATA_W-1:0]   data_out;
		logic [POS_W-1:0]    position;
		logic                found;
		logic [STATUS_W-1:0] status;
	} out_beat_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             latch;
		logic [ACT_W-1:0] act;
	} ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             empty;
		logic             hit;
		logic             more;
		logic             out_free;
	} stat_t;

endpackage

`default_nettype wire

>>> design/bounded_unsorted_list_table_unit.sv
// A taken command beat is decoded and then published directly for insert, clear, rewind,
// an unused code and any command on an empty table; get-next adds a read step, search and
// insert-unique a scan that compares one key a cycle, and delete that scan, a shift that
// moves the keys behind the match down one a cycle, and a final count update. The next beat
// is taken once the controller is back in idle after publishing; a held result stalls publish.
// Asynchronous active-low reset empties the table and zeroes the cursor; keys are not cleared.
`default_nettype none

module bounded_unsorted_list_table_unit #(
	parameter int MAX_ENTRIES = bult_pkg::DEF_MAX_ENTRIES,
	parameter int KEY_WIDTH   = bult_pkg::DEF_KEY_WIDTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Command beats.
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// Fields from bit 0: cmd[2:0], key[34:3], zero padding[39:35].
	input  wire logic [bult_pkg::IN_BEAT_W-1:0] s_tdata,
	// Result beats.
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// Fields from bit 0: status[2:0], found[3], position[7:4], data_out[39:8],
	// entry_count[44:40], zero padding[47:45].
	output logic [bult_pkg::OUT_BEAT_W-1:0]     m_tdata
);

	// The controller walks the command through decode, a scan over the stored
	// keys, the gap-closing shift after a delete, the get-next read and the
	// publish step that moves the finished result into the output register. The
	// datapath owns the key memory and all counters and reports back compare results.
	bult_pkg::ctrl_t ctrl;
	bult_pkg::stat_t st;

	bult_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.ctrl     (ctrl)
	);

	// The output register lets the next command beat be taken while the
	// previous result beat still waits for the downstream side.
	bult_dpath #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.KEY_WIDTH   (KEY_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.in_data   (s_tdata),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata),
		.st        (st)
	);

endmodule

`default_nettype wire

>>> design/bult_ctrl.sv
// Controller state machine of the bounded unsorted list table.
// Depends on bult_pkg for command, action and status types.
`default_nettype none

module bult_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire bult_pkg::stat_t st,
	output bult_pkg::ctrl_t     ctrl
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_SHIFT  = 3'd3;
	localparam logic [2:0] S_GET    = 3'd4;
	localparam logic [2:0] S_FIN    = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d    = state_q;
		ctrl.latch = 1'b0;
		ctrl.act   = bult_pkg::ACT_NONE;
		unique case (state_q)
			S_IDLE: begin
				ctrl.latch = in_valid;
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				ctrl.act = bult_pkg::ACT_DECODE;
				state_d  = S_FIN;
				unique case (st.cmd) inside
					bult_pkg::CMD_UNIQUE, bult_pkg::CMD_DELETE, bult_pkg::CMD_SEARCH: begin
						if (!st.empty) begin
							state_d = S_SCAN;
						end
					end
					bult_pkg::CMD_GET: begin
						if (!st.empty) begin
							state_d = S_GET;
						end
					end
					default: begin
						state_d = S_FIN;
					end
				endcase
			end
			S_SCAN: begin
				ctrl.act = bult_pkg::ACT_SCAN;
				if (st.hit) begin
					state_d = (st.cmd == bult_pkg::CMD_DELETE) ? S_SHIFT : S_FIN;
				end else if (!st.more) begin
					state_d = S_FIN;
				end
			end
			S_SHIFT: begin
				ctrl.act = bult_pkg::ACT_SHIFT;
				if (!st.more) begin
					state_d = S_FIN;
				end
			end
			S_GET: begin
				ctrl.act = bult_pkg::ACT_GET;
				state_d  = S_FIN;
			end
			S_FIN: begin
				ctrl.act = bult_pkg::ACT_PUBLISH;
				if (st.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

>>> design/bult_dpath.sv
// Datapath of the bounded unsorted list table: key memory, count, cursor,
// scan index, result and output registers. Depends on bult_pkg.
`default_nettype none

module bult_dpath #(
	parameter int MAX_ENTRIES = bult_pkg::DEF_MAX_ENTRIES,
	parameter int KEY_WIDTH   = bult_pkg::DEF_KEY_WIDTH
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire bult_pkg::ctrl_t                   ctrl,
	input  wire logic [bult_pkg::IN_BEAT_W-1:0]    in_data,
	input  wire logic                              out_ready,
	output logic                                   out_valid,
	output logic [bult_pkg::OUT_BEAT_W-1:0]        out_data,
	output bult_pkg::stat_t                        st
);

	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	bult_pkg::in_beat_t  in_beat;
	bult_pkg::out_beat_t out_q;

	logic [KEY_WIDTH-1:0] mem [MAX_ENTRIES];
	logic [KEY_WIDTH-1:0] rd_data_q;

	logic [bult_pkg::CMD_W-1:0]    cmd_q;
	logic [KEY_WIDTH-1:0]          key_q;
	logic [CW-1:0]                 count_q, count_d;
	logic [IW-1:0]                 cursor_q, cursor_d;
	logic [IW-1:0]                 idx_q, idx_d;
	logic [IW-1:0]                 pos_q, pos_d;
	logic [bult_pkg::STATUS_W-1:0] res_status_q, res_status_d;
	logic                          res_found_q, res_found_d;
	logic [KEY_WIDTH-1:0]          res_data_q, res_data_d;
	logic                          out_valid_q;

	logic                 we;
	logic [IW-1:0]        wa;
	logic [KEY_WIDTH-1:0] wd;
	logic [IW-1:0]        ra;

	logic          full;
	logic          empty;
	logic          hit;
	logic          more;
	logic          out_free;
	logic [CW-1:0] idx_p1;
	logic [CW-1:0] pos_p1;
	logic [IW-1:0] cur_eff;

	assign in_beat  = bult_pkg::in_beat_t'(in_data);
	assign full     = (count_q >= CW'(MAX_ENTRIES));
	assign empty    = (count_q == '0);
	assign hit      = (rd_data_q == key_q);
	assign idx_p1   = CW'(idx_q) + CW'(1);
	assign pos_p1   = CW'(pos_q) + CW'(1);
	assign more     = (idx_p1 < count_q);
	assign out_free = !out_valid_q || out_ready;
	assign cur_eff  = (CW'(cursor_q) >= count_q) ? '0 : cursor_q;

	assign st.cmd      = cmd_q;
	assign st.empty    = empty;
	assign st.hit      = hit;
	assign st.more     = more;
	assign st.out_free = out_free;

	always_comb begin
		count_d      = count_q;
		cursor_d     = cursor_q;
		idx_d        = idx_q;
		pos_d        = pos_q;
		res_status_d = res_status_q;
		res_found_d  = res_found_q;
		res_data_d   = res_data_q;
		we           = 1'b0;
		wa           = IW'(count_q);
		wd           = key_q;
		ra           = '0;
		unique case (ctrl.act)
			bult_pkg::ACT_DECODE: begin
				res_status_d = bult_pkg::ST_OK;
				res_found_d  = 1'b0;
				res_data_d   = '0;
				pos_d        = '0;
				idx_d        = '0;
				case (cmd_q) inside
					bult_pkg::CMD_INSERT: begin
						if (full) begin
							res_status_d = bult_pkg::ST_FULL;
						end else begin
							we      = 1'b1;
							count_d = count_q + CW'(1);
						end
					end
					bult_pkg::CMD_UNIQUE: begin
						// An empty table holds no duplicate, so append at once.
						if (empty) begin
							we      = 1'b1;
							count_d = count_q + CW'(1);
						end
					end
					bult_pkg::CMD_DELETE, bult_pkg::CMD_SEARCH: begin
						if (empty) begin
							res_status_d = bult_pkg::ST_NOT_FOUND;
						end
					end
					bult_pkg::CMD_CLEAR: begin
						count_d  = '0;
						cursor_d = '0;
					end
					bult_pkg::CMD_REWIND: begin
						cursor_d = '0;
					end
					bult_pkg::CMD_GET: begin
						if (empty) begin
							res_status_d = bult_pkg::ST_EMPTY;
						end else begin
							ra    = cur_eff;
							pos_d = cur_eff;
						end
					end
					default: begin
						res_status_d = bult_pkg::ST_OK;
					end
				endcase
			end
			bult_pkg::ACT_SCAN: begin
				if (hit) begin
					res_found_d = 1'b1;
					pos_d       = idx_q;
					if (cmd_q == bult_pkg::CMD_UNIQUE) begin
						res_status_d = bult_pkg::ST_DUPLICATE;
					end
					// Fetch the entry behind the match for the gap closing.
					ra = IW'(idx_p1);
				end else if (more) begin
					idx_d = IW'(idx_p1);
					ra    = IW'(idx_p1);
				end else if (cmd_q == bult_pkg::CMD_UNIQUE) begin
					if (full) begin
						res_status_d = bult_pkg::ST_FULL;
					end else begin
						we      = 1'b1;
						count_d = count_q + CW'(1);
					end
				end else begin
					res_status_d = bult_pkg::ST_NOT_FOUND;
				end
			end
			bult_pkg::ACT_SHIFT: begin
				if (more) begin
					we    = 1'b1;
					wa    = idx_q;
					wd    = rd_data_q;
					idx_d = IW'(idx_p1);
					ra    = idx_q + IW'(2);
				end else begin
					count_d = count_q - CW'(1);
				end
			end
			bult_pkg::ACT_GET: begin
				res_data_d = rd_data_q;
				cursor_d   = (pos_p1 >= count_q) ? '0 : IW'(pos_p1);
			end
			default: begin
				ra = '0;
			end
		endcase
	end

	// Key store: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_data_q <= mem[ra];
	end

	always_ff @(posedge clk) begin
		if (ctrl.latch) begin
			cmd_q <= in_beat.cmd;
			key_q <= KEY_WIDTH'(in_beat.key);
		end
		idx_d_reg: begin
			idx_q        <= idx_d;
			pos_q        <= pos_d;
			res_status_q <= res_status_d;
			res_found_q  <= res_found_d;
			res_data_q   <= res_data_d;
		end
		if ((ctrl.act == bult_pkg::ACT_PUBLISH) && out_free) begin
			out_q.pad         <= '0;
			out_q.entry_count <= bult_pkg::COUNT_W'(count_q);
			out_q.data_out    <= bult_pkg::DATA_W'(res_data_q);
			out_q.position    <= bult_pkg::POS_W'(pos_q);
			out_q.found       <= res_found_q;
			out_q.status      <= res_status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cursor_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q  <= count_d;
			cursor_q <= cursor_d;
			if ((ctrl.act == bult_pkg::ACT_PUBLISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for bounded_unsorted_list_table_unit: stream driver, result monitor
// and an in-bench model of the key table. Depends on bult_pkg and the unit itself.

module tb_top;
	import bult_pkg::*;

	localparam int          TABLE_DEPTH  = DEF_MAX_ENTRIES;
	localparam int          RANDOM_ITEMS = 1880;
	localparam int          DRAIN_EVERY  = 300;
	localparam int          TAIL_CYCLES  = 2 * TABLE_DEPTH + 32;
	localparam int          CYCLE_LIMIT  = 500000;
	localparam int          IDLE_PERCENT = 16;
	localparam int          POOL_SIZE    = 8;
	// Command code that the unit treats as a no-operation.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

	// One queued command beat plus the pacing hints that travel with it.
	typedef struct {
		in_beat_t beat;
		bit       drain_first;
		bit       calm;
	} cmd_item_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      s_tvalid = 1'b0;
	logic      s_tready;
	in_beat_t  s_tdata = '0;
	logic      m_tvalid;
	logic      m_tready = 1'b0;
	logic [OUT_BEAT_W-1:0] m_tdata;

	cmd_item_t   cmd_backlog[$];
	out_beat_t   predicted_replies[$];
	bit          in_taken = 1'b0;
	bit          calm_now = 1'b0;
	bit          drain_next = 1'b0;
	bit          calm_stretch = 1'b0;
	int unsigned planned = 0;
	int unsigned cycle_cnt = 0;
	int unsigned mismatch_count = 0;
	int unsigned cmds_accepted = 0;
	int unsigned replies_checked = 0;
	int unsigned status_tally [5];
	logic [DEF_KEY_WIDTH-1:0] key_pool [POOL_SIZE];

	// Model of the table: stored keys in insertion order, count and read cursor.
	logic [DEF_KEY_WIDTH-1:0] tbl_keys [TABLE_DEPTH];
	int tbl_count = 0;
	int tbl_cursor = 0;

	bounded_unsorted_list_table_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	// Applies one command to the table model and returns the reply it should give.
	function automatic out_beat_t table_apply(input logic [CMD_W-1:0] cmd,
			input logic [DEF_KEY_WIDTH-1:0] key);
		out_beat_t r;
		int hit_at;
		r = '0;
		hit_at = -1;
		for (int i = 0; i < tbl_count; i++) begin
			if (hit_at < 0 && tbl_keys[i] == key) begin
				hit_at = i;
			end
		end
		case (cmd)
			CMD_INSERT: begin
				if (tbl_count >= TABLE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					tbl_keys[tbl_count] = key;
					tbl_count++;
				end
			end
			CMD_UNIQUE: begin
				// A stored copy is reported even when the table is full.
				if (hit_at >= 0) begin
					r.status   = ST_DUPLICATE;
					r.found    = 1'b1;
					r.position = POS_W'(hit_at);
				end else if (tbl_count >= TABLE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					tbl_keys[tbl_count] = key;
					tbl_count++;
				end
			end
			CMD_DELETE: begin
				if (hit_at >= 0) begin
					for (int i = hit_at; i + 1 < tbl_count; i++) begin
						tbl_keys[i] = tbl_keys[i + 1];
					end
					tbl_count--;
					r.found    = 1'b1;
					r.position = POS_W'(hit_at);
				end else begin
					r.status = ST_NOT_FOUND;
				end
			end
			CMD_SEARCH: begin
				if (hit_at >= 0) begin
					r.found    = 1'b1;
					r.position = POS_W'(hit_at);
				end else begin
					r.status = ST_NOT_FOUND;
				end
			end
			CMD_CLEAR: begin
				tbl_count  = 0;
				tbl_cursor = 0;
			end
			CMD_REWIND: begin
				tbl_cursor = 0;
			end
			CMD_GET: begin
				if (tbl_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					// Deletes may leave the cursor beyond the last key; it restarts at the head.
					if (tbl_cursor >= tbl_count) begin
						tbl_cursor = 0;
					end
					r.data_out = tbl_keys[tbl_cursor];
					r.position = POS_W'(tbl_cursor);
					tbl_cursor++;
					if (tbl_cursor >= tbl_count) begin
						tbl_cursor = 0;
					end
				end
			end
			default: begin
			end
		endcase
		r.entry_count = COUNT_W'(tbl_count);
		return r;
	endfunction

	task automatic flag_field(input string field, input logic [DEF_KEY_WIDTH-1:0] want,
			input logic [DEF_KEY_WIDTH-1:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, field,
					want, got);
			end
		end
	endtask

	task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [DEF_KEY_WIDTH-1:0] key);
		cmd_item_t it;
		it.beat        = '0;
		it.beat.cmd    = cmd;
		it.beat.key    = key;
		it.drain_first = drain_next;
		it.calm        = calm_stretch;
		drain_next     = 1'b0;
		cmd_backlog.push_back(it);
		planned++;
	endtask

	task automatic refresh_pool();
		for (int i = 0; i < POOL_SIZE; i++) begin
			case ($urandom_range(9))
				0: key_pool[i] = '0;
				1: key_pool[i] = '1;
				default: key_pool[i] = $urandom;
			endcase
		end
	endtask

	// Mostly keys from a small pool, so that searches, deletes and duplicates hit.
	function automatic logic [DEF_KEY_WIDTH-1:0] pick_key();
		if ($urandom_range(99) < 85) begin
			return key_pool[$urandom_range(POOL_SIZE - 1)];
		end
		return $urandom;
	endfunction

	// Driver: presents command beats and the result-side ready, both at the falling edge.
	always @(negedge clk) begin
		logic     nv;
		in_beat_t nd;
		if (arst_n) begin
			nv = s_tvalid;
			nd = s_tdata;
			if (!s_tvalid || in_taken) begin
				nv = 1'b0;
				// A beat marked for draining waits until every reply in flight is back.
				if (cmd_backlog.size() != 0
						&& !(cmd_backlog[0].drain_first && predicted_replies.size() != 0)
						&& (calm_now || $urandom_range(99) >= IDLE_PERCENT)) begin
					nv       = 1'b1;
					nd       = cmd_backlog[0].beat;
					calm_now = cmd_backlog[0].calm;
					void'(cmd_backlog.pop_front());
				end
			end
			s_tvalid <= nv;
			s_tdata  <= nd;
			m_tready <= calm_now || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// Monitor: checks each result beat, then predicts the reply to any command beat taken.
	always @(posedge clk) begin
		out_beat_t got;
		out_beat_t want;
		if (arst_n) begin
			in_taken <= s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (predicted_replies.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("%0t ns: result beat 0x%0h arrived with none expected",
							$realtime, got);
					end
				end else begin
					want = predicted_replies.pop_front();
					flag_field("status", want.status, got.status);
					flag_field("found", want.found, got.found);
					flag_field("position", want.position, got.position);
					flag_field("data_out", want.data_out, got.data_out);
					flag_field("entry_count", want.entry_count, got.entry_count);
					flag_field("padding", want.pad, got.pad);
					replies_checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				want = table_apply(s_tdata.cmd, s_tdata.key);
				predicted_replies.push_back(want);
				status_tally[want.status]++;
				cmds_accepted++;
			end
		end
	end

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("Timed out after %0d cycles", cycle_cnt);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int n;
		int r;
		int next_drain_at;
		logic [DEF_KEY_WIDTH-1:0] kept;

		// Directed opening: empty-table corners, extreme keys, head and tail deletes,
		// cursor restart after a delete, wrap, rewind, the unused code and clear.
		queue_cmd(CMD_GET, '0);
		queue_cmd(CMD_DELETE, '0);
		queue_cmd(CMD_SEARCH, '1);
		queue_cmd(CMD_INSERT, '0);
		queue_cmd(CMD_INSERT, '1);
		queue_cmd(CMD_UNIQUE, '1);
		queue_cmd(CMD_UNIQUE, 32'h5A5A_C3C3);
		queue_cmd(CMD_SEARCH, 32'h5A5A_C3C3);
		queue_cmd(CMD_GET, '0);
		queue_cmd(CMD_GET, '0);
		queue_cmd(CMD_DELETE, '0);
		queue_cmd(CMD_GET, '0);
		queue_cmd(CMD_GET, '0);
		queue_cmd(CMD_DELETE, 32'h5A5A_C3C3);
		queue_cmd(CMD_REWIND, '0);
		queue_cmd(CMD_GET, '0);
		queue_cmd(CMD_UNUSED, '1);
		queue_cmd(CMD_INSERT, 32'h8000_0001);
		queue_cmd(CMD_CLEAR, '1);
		queue_cmd(CMD_GET, '0);
		queue_cmd(CMD_SEARCH, '1);

		// Random part, built from short episodes so the table really fills and empties.
		planned       = 0;
		next_drain_at = 0;
		while (planned < RANDOM_ITEMS) begin
			if (planned >= next_drain_at) begin
				drain_next    = 1'b1;
				next_drain_at = next_drain_at + DRAIN_EVERY;
			end
			// A stretch in the middle runs with neither side idling.
			calm_stretch = (planned >= 800 && planned < 1100);
			refresh_pool();
			case ($urandom_range(9))
				0, 1: begin
					// Fill past capacity, then probe the full table.
					queue_cmd(CMD_CLEAR, $urandom);
					n    = $urandom_range(TABLE_DEPTH, TABLE_DEPTH + 4);
					kept = $urandom;
					for (int i = 0; i < n; i++) begin
						kept = ($urandom_range(3) == 0) ? pick_key() : $urandom;
						queue_cmd(($urandom_range(3) == 0) ? CMD_UNIQUE : CMD_INSERT, kept);
					end
					queue_cmd(CMD_UNIQUE, kept);
					queue_cmd(CMD_UNIQUE, $urandom);
					queue_cmd(CMD_SEARCH, kept);
					queue_cmd(CMD_DELETE, pick_key());
					queue_cmd(CMD_GET, '0);
				end
				2, 3: begin
					// Walk through the table, with the odd delete moving keys under the cursor.
					queue_cmd(CMD_REWIND, $urandom);
					n = $urandom_range(1, 20);
					for (int i = 0; i < n; i++) begin
						if ($urandom_range(9) == 0) begin
							queue_cmd(CMD_DELETE, pick_key());
						end else begin
							queue_cmd(CMD_GET, $urandom);
						end
					end
				end
				9: begin
					n = $urandom_range(5, 15);
					for (int i = 0; i < n; i++) begin
						queue_cmd(CMD_W'($urandom_range(7)), $urandom);
					end
				end
				default: begin
					n = $urandom_range(10, 40);
					for (int i = 0; i < n; i++) begin
						r = $urandom_range(99);
						if (r < 22) queue_cmd(CMD_INSERT, pick_key());
						else if (r < 40) queue_cmd(CMD_UNIQUE, pick_key());
						else if (r < 62) queue_cmd(CMD_DELETE, pick_key());
						else if (r < 77) queue_cmd(CMD_SEARCH, pick_key());
						else if (r < 92) queue_cmd(CMD_GET, $urandom);
						else if (r < 95) queue_cmd(CMD_REWIND, $urandom);
						else if (r < 97) queue_cmd(CMD_CLEAR, $urandom);
						else queue_cmd(CMD_UNUSED, $urandom);
					end
				end
			endcase
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || s_tvalid || predicted_replies.size() != 0) begin
			@(posedge clk);
		end
		// Any stray beat after the last reply is caught by the monitor.
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d commands and checked %0d replies in %0d cycles.", cmds_accepted,
			replies_checked, cycle_cnt);
		$display("Replies seen: %0d ok, %0d full, %0d not found, %0d empty, %0d duplicate.",
			status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_NOT_FOUND],
			status_tally[ST_EMPTY], status_tally[ST_DUPLICATE]);
		if (mismatch_count == 0 && predicted_replies.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
